// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a consequent in the same cycle as its antecedent.
`define CHK_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Check a consequent in the cycle after its antecedent.
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== hw/rtl/tplr_pkg.sv =====
package tplr_pkg;

    // Coordinate and address widths
    localparam int COORD_W   = 10;
    localparam int ADDR_W    = 21;
    localparam int BYTE_SH   = 2;
    localparam int IDX_W     = ADDR_W - BYTE_SH;

    // Restoring divider: one quotient bit per cycle
    localparam int DIV_STEPS = COORD_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    // Input command codes
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    typedef logic [COORD_W-1:0] t_coord;

    // Controller to datapath commands
    typedef struct packed {
        logic load;         // capture endpoints
        logic setup;        // arm a pass and clear the divider
        logic setup_pass2;  // pass selected by setup
        logic div_step;     // one divider iteration
        logic emit;         // output a pixel and advance the walk
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic dx_nz;
        logic dy_nz;
        logic pass_end;
        logic pass2;
        logic out_full;
    } t_status;

endpackage

// ===== hw/rtl/tplr_datapath.sv =====
module tplr_datapath import tplr_pkg::*; #(
    parameter int SCREEN_WIDTH = 800
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_coord            i_start_x,
    input  t_coord            i_start_y,
    input  t_coord            i_end_x,
    input  t_coord            i_end_y,
    input  logic              i_stall,
    input  t_cmd              i_cmd,
    output t_status           o_status,
    output logic              o_valid,
    output t_coord            o_pixel_x,
    output t_coord            o_pixel_y,
    output logic [ADDR_W-1:0] o_pixel_address,
    output logic              o_last_pixel
);

    localparam int WW = $clog2(SCREEN_WIDTH + 1);

    // Endpoints
    t_coord r_sx, r_sy, r_ex, r_ey;
    // Walk state
    t_coord r_pos, r_oth, r_rem;
    logic   r_pass2, r_walk_dec, r_oth_neg;
    // Divider: r_dvd ends as the per-step quotient, r_drem as the per-step remainder
    t_coord r_dvs, r_dvd, r_drem;
    // Output word
    logic              r_out_valid;
    t_coord            r_px, r_py;
    logic [ADDR_W-1:0] r_addr;
    logic              r_last;

    t_coord dx_mag, dy_mag, walk_end, pos_next, inc, oth_next, rem_next;
    t_coord px, py;
    logic   pass_end, fits, carry;
    logic [COORD_W:0] drem_sh, drem_sub, acc;
    logic [COORD_W+WW-1:0] row_base;
    logic [IDX_W-1:0] pix_idx;

    // Span magnitudes of the stored line
    assign dx_mag = (r_ex >= r_sx) ? r_ex - r_sx : r_sx - r_ex;
    assign dy_mag = (r_ey >= r_sy) ? r_ey - r_sy : r_sy - r_ey;

    // Walked coordinate moves one toward its end
    assign walk_end = r_pass2 ? r_ey : r_ex;
    assign pos_next = r_walk_dec ? r_pos - 1'b1 : r_pos + 1'b1;
    assign pass_end = (pos_next == walk_end);

    // Divider iteration
    assign drem_sh  = {r_drem, r_dvd[COORD_W-1]};
    assign fits     = (drem_sh >= {1'b0, r_dvs});
    assign drem_sub = drem_sh - {1'b0, r_dvs};

    // Error-term accumulate for the other coordinate
    assign acc      = {1'b0, r_rem} + {1'b0, r_drem};
    assign carry    = (acc >= {1'b0, r_dvs});
    assign rem_next = carry ? COORD_W'(acc - {1'b0, r_dvs}) : acc[COORD_W-1:0];
    assign inc      = carry ? r_dvd + 1'b1 : r_dvd;
    assign oth_next = r_oth_neg ? r_oth - inc : r_oth + inc;

    // Current pixel and its frame buffer address
    assign px       = r_pass2 ? r_oth : r_pos;
    assign py       = r_pass2 ? r_pos : r_oth;
    assign row_base = py * WW'(SCREEN_WIDTH);
    assign pix_idx  = IDX_W'(row_base) + IDX_W'(px);

    // Capture endpoints
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sx <= i_start_x;
            r_sy <= i_start_y;
            r_ex <= i_end_x;
            r_ey <= i_end_y;
        end
    end

    // Arm a pass, run the divider, advance the walk
    always_ff @(posedge i_clk) begin
        if (i_cmd.setup) begin
            r_pass2 <= i_cmd.setup_pass2;
            r_rem   <= '0;
            r_drem  <= '0;
            if (i_cmd.setup_pass2) begin
                r_pos      <= r_sy;
                r_oth      <= r_sx;
                r_walk_dec <= (r_sy > r_ey);
                r_oth_neg  <= (r_ex < r_sx);
                r_dvs      <= dy_mag;
                r_dvd      <= dx_mag;
            end else begin
                r_pos      <= r_sx;
                r_oth      <= r_sy;
                r_walk_dec <= (r_sx > r_ex);
                r_oth_neg  <= (r_ey < r_sy);
                r_dvs      <= dx_mag;
                r_dvd      <= dy_mag;
            end
        end else if (i_cmd.div_step) begin
            r_drem <= fits ? drem_sub[COORD_W-1:0] : drem_sh[COORD_W-1:0];
            r_dvd  <= {r_dvd[COORD_W-2:0], fits};
        end else if (i_cmd.emit) begin
            r_pos <= pos_next;
            r_oth <= oth_next;
            r_rem <= rem_next;
        end
    end

    // Output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_px   <= px;
            r_py   <= py;
            r_addr <= {pix_idx, BYTE_SH'(0)};
            r_last <= pass_end && (r_pass2 || (r_sy == r_ey));
        end
    end

    assign o_status.dx_nz    = (r_sx != r_ex);
    assign o_status.dy_nz    = (r_sy != r_ey);
    assign o_status.pass_end = pass_end;
    assign o_status.pass2    = r_pass2;
    assign o_status.out_full = r_out_valid;

    assign o_valid         = r_out_valid;
    assign o_pixel_x       = r_px;
    assign o_pixel_y       = r_py;
    assign o_pixel_address = r_addr;
    assign o_last_pixel    = r_last;

endmodule

// ===== hw/rtl/tplr_ctrl.sv =====
module tplr_ctrl import tplr_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  logic    i_command,
    input  logic    i_stall,
    input  t_status i_status,
    output logic    o_stall,
    output t_cmd    o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SETUP = 4'b0010,
        S_DIV   = 4'b0100,
        S_WALK  = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic accept;

    // Take words only when not arming a pass or running the divider, and the output slot can drain
    assign o_stall = !((r_state == S_IDLE) || (r_state == S_WALK))
                     || (i_status.out_full && i_stall);
    assign accept  = i_valid && !o_stall;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (accept && (i_command == CMD_LOAD)) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SETUP;
                end
            end
            S_SETUP: begin
                n_cnt = '0;
                if (i_status.dx_nz) begin
                    o_cmd.setup = 1'b1;
                    n_state     = S_DIV;
                end else if (i_status.dy_nz) begin
                    o_cmd.setup       = 1'b1;
                    o_cmd.setup_pass2 = 1'b1;
                    n_state           = S_DIV;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (accept && (i_command == CMD_LOAD)) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SETUP;
                end else if (accept) begin
                    o_cmd.emit = 1'b1;
                    if (i_status.pass_end) begin
                        if (!i_status.pass2 && i_status.dy_nz) begin
                            o_cmd.setup       = 1'b1;
                            o_cmd.setup_pass2 = 1'b1;
                            n_cnt             = '0;
                            n_state           = S_DIV;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state and divider count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

// ===== hw/rtl/two_pass_line_rasterizer_unit.sv =====
// Two-pass line rasterizer. A load word (command 0) stores two endpoints; each
// step word (command 1) then returns one pixel with its x, y and byte address
// (y * SCREEN_WIDTH + x) * 4, wrapped to 21 bits, and last_pixel set on the
// final pixel. The first pass walks x from start toward end (end excluded),
// the second walks y the same way; a pass with zero span is skipped, and a
// step with no line loaded returns nothing. After a load the input stalls
// through the setup state and the run of the shared restoring divider (one
// quotient bit per cycle), which forms the per-step slope; a load whose two
// endpoints coincide stalls it in the setup state only. Then one step word
// is taken per cycle unless a held result blocks it, and its pixel appears
// in the next cycle. At the change from the first pass to the second the
// divider runs again, so the input stalls after the last pixel of the first
// pass while it runs. A result held by a stalled receiver occupies the single
// output register and blocks the next word.
module two_pass_line_rasterizer_unit import tplr_pkg::*; #(
    parameter int SCREEN_WIDTH = 800
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic              i_command,
    input  t_coord            i_start_x,
    input  t_coord            i_start_y,
    input  t_coord            i_end_x,
    input  t_coord            i_end_y,
    output logic              o_valid,
    input  logic              i_stall,
    output t_coord            o_pixel_x,
    output t_coord            o_pixel_y,
    output logic [ADDR_W-1:0] o_pixel_address,
    output logic              o_last_pixel
);

    t_cmd    cmd;
    t_status status;

    // Sequence loads, divider runs and steps
    tplr_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_command (i_command),
        .i_stall   (i_stall),
        .i_status  (status),
        .o_stall   (o_stall),
        .o_cmd     (cmd)
    );

    // Endpoints, divider, walk and output word
    tplr_datapath #(
        .SCREEN_WIDTH (SCREEN_WIDTH)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start_x       (i_start_x),
        .i_start_y       (i_start_y),
        .i_end_x         (i_end_x),
        .i_end_y         (i_end_y),
        .i_stall         (i_stall),
        .i_cmd           (cmd),
        .o_status        (status),
        .o_valid         (o_valid),
        .o_pixel_x       (o_pixel_x),
        .o_pixel_y       (o_pixel_y),
        .o_pixel_address (o_pixel_address),
        .o_last_pixel    (o_last_pixel)
    );

endmodule

// ===== hw/rtl/tplr_checker.sv =====
`include "assert_macros.svh"

module tplr_checker import tplr_pkg::*; #(
    parameter int SCREEN_WIDTH = 800
) (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              o_stall,
    input logic              i_command,
    input logic              o_valid,
    input logic              i_stall,
    input t_coord            o_pixel_x,
    input t_coord            o_pixel_y,
    input logic [ADDR_W-1:0] o_pixel_address
);

    localparam int WW = $clog2(SCREEN_WIDTH + 1);

    logic                  load_taken;
    logic [COORD_W+WW-1:0] row_base;
    logic [IDX_W-1:0]      pix_idx;
    logic [ADDR_W-1:0]     exp_addr;

    // Expected address of the shown pixel
    assign load_taken = i_valid && !o_stall && (i_command == CMD_LOAD);
    assign row_base   = o_pixel_y * WW'(SCREEN_WIDTH);
    assign pix_idx    = IDX_W'(row_base) + IDX_W'(o_pixel_x);
    assign exp_addr   = {pix_idx, BYTE_SH'(0)};

    `CHK_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid)
    `CHK_NEXT(a_out_stable, i_clk, i_rst_n, o_valid && i_stall, $stable(o_pixel_address))
    `CHK_SAME(a_addr_match, i_clk, i_rst_n, o_valid, o_pixel_address == exp_addr)
    `CHK_NEXT(a_load_no_word, i_clk, i_rst_n, load_taken, !o_valid)
    `CHK_NEXT(a_load_setup, i_clk, i_rst_n, load_taken, o_stall)

endmodule

bind two_pass_line_rasterizer_unit tplr_checker #(
    .SCREEN_WIDTH (SCREEN_WIDTH)
) u_checker (.*);
